// ===== sv/snm_pkg.sv =====
`default_nettype none
package snm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GRAD_W = 12;
  localparam int ABS_W = 10;
  localparam int MAG_W = 24;
  localparam int RAD_W = 48;
  localparam int ROOT_W = 24;

  localparam logic [MAG_W-1:0] NORM_K = 24'd65280;
  localparam logic [RAD_W-1:0] NORM_K2 = 48'd4261478400;
  localparam logic [13:0] STRENGTH_MAX = 14'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_STRENGTH,
    REG_INV_RED,
    REG_INV_GREEN
  } cfg_reg_t;

  typedef struct packed {
    logic [10:0] width;
    logic [15:0] height;
    logic [13:0] strength;
    logic        inv_x;
    logic        inv_y;
  } cfg_t;

  // [column][row], column 0 leftmost, row 0 top
  typedef logic [2:0][2:0][7:0] win_t;

  typedef struct packed {
    logic start;
    win_t win;
  } emit_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
  } emit_res_t;

  function automatic logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [16:0] acc;
    acc = 17'd77 * {9'd0, r} + 17'd150 * {9'd0, g} + 17'd29 * {9'd0, b} + 17'd128;
    return acc[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== sv/snm_if.sv =====
`default_nettype none
interface snm_pix_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, command, red, green, blue, input ready);
  modport sink (input valid, command, red, green, blue, output ready);
endinterface

interface snm_nrm_if;
  logic       valid;
  logic       ready;
  logic [7:0] normal_x;
  logic [7:0] normal_y;
  logic [7:0] normal_z;
  logic       last_of_run;
  logic       end_of_frame;
  modport source (output valid, normal_x, normal_y, normal_z, last_of_run, end_of_frame,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, last_of_run, end_of_frame,
                output ready);
endinterface

interface snm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/snm_cfg.sv =====
`default_nettype none
module snm_cfg import snm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  snm_cfg_if.sink   cfg,
  output cfg_t      cfg_eff
);

  logic [10:0] frame_width;
  logic [15:0] frame_height;
  logic [13:0] strength_q8;
  logic        invert_red;
  logic        invert_green;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd256;
      frame_height <= 16'd256;
      strength_q8  <= 14'd256;
      invert_red   <= 1'b0;
      invert_green <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_WIDTH:     frame_width  <= cfg.data[10:0];
        REG_HEIGHT:    frame_height <= cfg.data;
        REG_STRENGTH:  strength_q8  <= cfg.data[13:0];
        REG_INV_RED:   invert_red   <= cfg.data[0];
        REG_INV_GREEN: invert_green <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff.width    = (frame_width == 11'd0) ? 11'd1 : frame_width;
    cfg_eff.height   = (frame_height == 16'd0) ? 16'd1 : frame_height;
    cfg_eff.strength = (strength_q8 > STRENGTH_MAX) ? STRENGTH_MAX : strength_q8;
    cfg_eff.inv_x    = invert_red;
    cfg_eff.inv_y    = invert_green;
  end

endmodule
`default_nettype wire

// ===== sv/snm_emit.sv =====
`default_nettype none
module snm_emit import snm_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg_eff,
  input  emit_req_t req,
  output emit_res_t res
);

  localparam int F = FRACTION_BITS;
  localparam int QB = F + 1;
  localparam int NW = MAG_W + F + 1;
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int MAXN = (QB > SQ_STEPS) ? QB : SQ_STEPS;
  localparam int CNTW = $clog2(MAXN + 1);
  localparam logic [QB-1:0] ONE = QB'(1) << F;

  typedef enum logic [3:0] {
    S_IDLE, S_MX, S_MY, S_SX, S_SY, S_SUM, S_SQRT, S_DINIT, S_DIV, S_ENC
  } state_t;

  state_t            state;
  win_t              win;
  logic [CNTW-1:0]   cnt;
  logic [MAG_W-1:0]  mag_x, mag_y;
  logic [RAD_W-1:0]  sq_x, sq_y;
  logic [RAD_W-1:0]  rad, root, bitm;
  logic [ROOT_W-1:0] rem [3];
  logic [QB-1:0]     quo [3];

  logic signed [GRAD_W-1:0] gx, gy;
  logic [ABS_W-1:0]  abs_x, abs_y, mul_a;
  logic [MAG_W-1:0]  prod;
  logic [MAG_W-1:0]  sq_in;
  logic [RAD_W-1:0]  sq;
  logic [RAD_W-1:0]  trial;
  logic [MAG_W-1:0]  lane_mag [3];
  logic              lane_neg [3];

  function automatic logic [GRAD_W-1:0] sum3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return {4'd0, a} + {3'd0, b, 1'b0} + {4'd0, c};
  endfunction

  function automatic logic [7:0] encode(logic [QB-1:0] q, logic neg);
    logic [QB-1:0] qc;
    logic [QB:0]   sh;
    logic [QB+8:0] p;
    logic [QB+8:0] code_w;
    qc = (q > ONE) ? ONE : q;
    sh = neg ? ({1'b0, ONE} - {1'b0, qc}) : ({1'b0, ONE} + {1'b0, qc});
    p = {sh, 8'd0} - {8'd0, sh} + {9'd0, ONE};
    code_w = p >> QB;
    return (code_w > (QB+9)'(255)) ? 8'd255 : code_w[7:0];
  endfunction

  always_comb begin
    gx = $signed(sum3(win[2][0], win[2][1], win[2][2]))
       - $signed(sum3(win[0][0], win[0][1], win[0][2]));
    gy = $signed(sum3(win[0][2], win[1][2], win[2][2]))
       - $signed(sum3(win[0][0], win[1][0], win[2][0]));
    abs_x = gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
    abs_y = gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
    mul_a = (state == S_MX) ? abs_x : abs_y;
    prod  = {{(MAG_W-ABS_W){1'b0}}, mul_a} * {{(MAG_W-14){1'b0}}, cfg_eff.strength};
    sq_in = (state == S_SX) ? mag_x : mag_y;
    sq    = {{(RAD_W-MAG_W){1'b0}}, sq_in} * {{(RAD_W-MAG_W){1'b0}}, sq_in};
    trial = root + bitm;
    lane_mag[0] = mag_x;
    lane_mag[1] = mag_y;
    lane_mag[2] = NORM_K;
    lane_neg[0] = (!gx[GRAD_W-1] && gx != '0) ^ cfg_eff.inv_x;
    lane_neg[1] = (!gy[GRAD_W-1] && gy != '0) ^ cfg_eff.inv_y;
    lane_neg[2] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        S_IDLE: if (req.start) begin
          win   <= req.win;
          state <= S_MX;
        end
        S_MX: begin
          mag_x <= prod;
          state <= S_MY;
        end
        S_MY: begin
          mag_y <= prod;
          state <= S_SX;
        end
        S_SX: begin
          sq_x  <= sq;
          state <= S_SY;
        end
        S_SY: begin
          sq_y  <= sq;
          state <= S_SUM;
        end
        S_SUM: begin
          rad   <= sq_x + sq_y + NORM_K2;
          root  <= '0;
          bitm  <= RAD_W'(1) << (RAD_W - 2);
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (rad >= trial) begin
            rad  <= rad - trial;
            root <= (root >> 1) + bitm;
          end else begin
            root <= root >> 1;
          end
          bitm <= bitm >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == CNTW'(SQ_STEPS - 1)) state <= S_DINIT;
        end
        S_DINIT: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= ROOT_W'((({lane_mag[i], {F{1'b0}}, 1'b0} >> 1)
                               + NW'(root[ROOT_W-1:1])) >> QB);
            quo[i] <= QB'({lane_mag[i], {F{1'b0}}} + NW'(root[ROOT_W-1:1]));
          end
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if ({rem[i], quo[i][QB-1]} >= {1'b0, root[ROOT_W-1:0]}) begin
              rem[i] <= ROOT_W'({rem[i], quo[i][QB-1]} - {1'b0, root[ROOT_W-1:0]});
              quo[i] <= {quo[i][QB-2:0], 1'b1};
            end else begin
              rem[i] <= ROOT_W'({rem[i], quo[i][QB-1]});
              quo[i] <= {quo[i][QB-2:0], 1'b0};
            end
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(QB - 1)) state <= S_ENC;
        end
        S_ENC: begin
          res.x    <= encode(quo[0], lane_neg[0]);
          res.y    <= encode(quo[1], lane_neg[1]);
          res.z    <= encode(quo[2], lane_neg[2]);
          res.done <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/snm_core.sv =====
`default_nettype none
module snm_core import snm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg_eff,
  snm_pix_if.sink    pix,
  snm_nrm_if.source  nrm,
  output emit_req_t  req,
  input  emit_res_t  res
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = ((AW > 11) ? AW : 11) + 1;

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_CALC, S_SEND} state_t;

  state_t         state;
  logic [15:0]    mem [MAX_WIDTH];
  logic [15:0]    rdata;
  win_t           win_q;
  win_t           win2;
  logic [AW-1:0]  col, c_r;
  logic [15:0]    row;
  logic [7:0]     luma_r;
  logic           flush_r, last_r;
  logic           pend2, cur_last, cur_eof;
  logic [7:0]     out_x, out_y, out_z;
  logic           out_last, out_eof;

  logic           flushing, last_col, fire;
  logic [CW-1:0]  width_lim;
  logic [7:0]     mid, top, bot;
  win_t           nw, w1, w2;
  logic           e1, e2;

  assign pix.ready = (state == S_IDLE);
  assign fire      = pix.valid && pix.ready;
  assign flushing  = row >= cfg_eff.height;
  assign width_lim = (CW'(cfg_eff.width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                           : CW'(cfg_eff.width);
  assign last_col  = CW'(col) >= width_lim - CW'(1);

  assign nrm.valid        = (state == S_SEND);
  assign nrm.normal_x     = out_x;
  assign nrm.normal_y     = out_y;
  assign nrm.normal_z     = out_z;
  assign nrm.last_of_run  = out_last;
  assign nrm.end_of_frame = out_eof;

  always_comb begin
    mid = rdata[7:0];
    top = (row == 16'd1) ? mid : rdata[15:8];
    bot = flush_r ? mid : luma_r;
    nw[0] = win_q[1];
    nw[1] = win_q[2];
    nw[2][0] = top;
    nw[2][1] = mid;
    nw[2][2] = bot;
    w1[0] = (c_r == AW'(1)) ? nw[1] : nw[0];
    w1[1] = nw[1];
    w1[2] = nw[2];
    w2[0] = (c_r == '0) ? nw[2] : nw[1];
    w2[1] = nw[2];
    w2[2] = nw[2];
    e1 = (row != 16'd0) && (c_r != '0);
    e2 = (row != 16'd0) && last_r;
  end

  always_ff @(posedge clk) begin
    if (fire) rdata <= mem[col];
    if (state == S_UPD) mem[c_r] <= {mid, bot};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      win_q     <= '0;
      col       <= '0;
      row       <= '0;
      req.start <= 1'b0;
      pend2     <= 1'b0;
    end else begin
      req.start <= 1'b0;
      unique case (state)
        S_IDLE: if (fire && !(pix.command && !flushing)) begin
          luma_r  <= luma(pix.red, pix.green, pix.blue);
          flush_r <= flushing;
          last_r  <= last_col;
          c_r     <= col;
          state   <= S_UPD;
        end
        S_UPD: begin
          win_q <= nw;
          win2  <= w2;
          if (last_r) begin
            col <= '0;
            row <= flush_r ? 16'd0 : row + 16'd1;
          end else begin
            col <= c_r + AW'(1);
          end
          if (e1) begin
            req.start <= 1'b1;
            req.win   <= w1;
            pend2     <= e2;
            cur_last  <= !e2;
            cur_eof   <= 1'b0;
            state     <= S_CALC;
          end else if (e2) begin
            req.start <= 1'b1;
            req.win   <= w2;
            pend2     <= 1'b0;
            cur_last  <= 1'b1;
            cur_eof   <= flush_r;
            state     <= S_CALC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CALC: if (res.done) begin
          out_x    <= res.x;
          out_y    <= res.y;
          out_z    <= res.z;
          out_last <= cur_last;
          out_eof  <= cur_eof;
          state    <= S_SEND;
        end
        S_SEND: if (nrm.ready) begin
          if (pend2) begin
            req.start <= 1'b1;
            req.win   <= win2;
            pend2     <= 1'b0;
            cur_last  <= 1'b1;
            cur_eof   <= flush_r;
            state     <= S_CALC;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/sobel_normal_map_generator.sv =====
// Flow: a pixel transfer is registered, then written into the line store; each result
//   takes 24 square-root steps and FRACTION_BITS + 1 divide steps in the normalize unit,
//   then an encode step.
// Items are taken one at a time; an item gives no result, one or two, and the next
//   item is taken only after its results have been sent, including any output stall.
// Reset: synchronous, active high; clears state, counters, window, config, not line store.
`default_nettype none
module sobel_normal_map_generator import snm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  snm_pix_if.sink    pix,
  snm_nrm_if.source  nrm,
  snm_cfg_if.sink    cfg
);

  cfg_t      cfg_eff;
  emit_req_t req;
  emit_res_t res;

  snm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_eff (cfg_eff)
  );

  snm_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg_eff (cfg_eff),
    .pix     (pix),
    .nrm     (nrm),
    .req     (req),
    .res     (res)
  );

  snm_emit #(.FRACTION_BITS(FRACTION_BITS)) u_emit (
    .clk     (clk),
    .rst     (rst),
    .cfg_eff (cfg_eff),
    .req     (req),
    .res     (res)
  );

endmodule
`default_nettype wire

// ===== sv/snm_checker.sv =====
`default_nettype none
module snm_checker (
  input logic       clk,
  input logic       rst,
  input logic       pix_ready,
  input logic       nrm_valid,
  input logic       nrm_ready,
  input logic [7:0] nrm_x,
  input logic       nrm_last,
  input logic       nrm_eof
);

  assert property (@(posedge clk) disable iff (rst)
    nrm_valid && !nrm_ready |=> nrm_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    nrm_valid && !nrm_ready |=> $stable(nrm_x) && $stable(nrm_last))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    nrm_valid && nrm_eof |-> nrm_last)
    else $error("frame end not last of run");

  assert property (@(posedge clk) disable iff (rst)
    nrm_valid |-> !pix_ready)
    else $error("input taken while result pending");

endmodule

bind sobel_normal_map_generator snm_checker u_snm_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pix.ready),
  .nrm_valid (nrm.valid),
  .nrm_ready (nrm.ready),
  .nrm_x     (nrm.normal_x),
  .nrm_last  (nrm.last_of_run),
  .nrm_eof   (nrm.end_of_frame)
);
`default_nettype wire

// ===== tb/sobel_normal_map_generator_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sobel_normal_map_generator_tb;
  import snm_pkg::*;

  localparam int LINE_MAX = 1024;
  localparam int FRAC = 16;
  localparam longint unsigned UNIT_Z = 65280;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    logic       last;
    logic       eof;
  } normal_t;

  typedef struct {
    bit         cmd;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         typed;
    logic [7:0] tx;
    logic [7:0] ty;
    logic [7:0] tz;
  } pix_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  snm_pix_if pix ();
  snm_nrm_if nrm ();
  snm_cfg_if cfg ();

  sobel_normal_map_generator dut (
    .clk(clk),
    .rst(rst),
    .pix(pix),
    .nrm(nrm),
    .cfg(cfg)
  );

  always #6 clk = ~clk;

  normal_t normal_q[$];
  int errors = 0;
  int pixels_taken = 0;
  int burst_left = 0;

  int unsigned cur_width = 256;
  int unsigned cur_height = 256;
  int unsigned cur_strength = 256;
  bit cur_inv_x = 0;
  bit cur_inv_y = 0;

  logic [7:0] line_above [LINE_MAX];
  logic [7:0] line_mid [LINE_MAX];
  logic [7:0] win_cols [9];
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;

  task automatic report(string what);
    $display("MISMATCH %0t: %s", $time, what);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] encode(longint comp, longint unsigned root, bit flip);
    longint unsigned one;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned shifted;
    longint unsigned code;
    bit neg;
    one = 64'd1 << FRAC;
    mag = comp < 0 ? -comp : comp;
    q = ((mag << FRAC) + root / 2) / root;
    neg = (comp < 0) != flip;
    if (q > one) q = one;
    shifted = neg ? one - q : one + q;
    code = (shifted * 255 + one) >> (FRAC + 1);
    return code > 255 ? 8'd255 : code[7:0];
  endfunction

  function automatic normal_t shade(logic [7:0] w [3][3]);
    normal_t res;
    int gx;
    int gy;
    longint s;
    longint a;
    longint b;
    longint unsigned root;
    s = cur_strength > 8192 ? 8192 : cur_strength;
    gx = (int'(w[2][0]) + 2 * int'(w[2][1]) + int'(w[2][2]))
       - (int'(w[0][0]) + 2 * int'(w[0][1]) + int'(w[0][2]));
    gy = (int'(w[0][2]) + 2 * int'(w[1][2]) + int'(w[2][2]))
       - (int'(w[0][0]) + 2 * int'(w[1][0]) + int'(w[2][0]));
    a = -longint'(gx) * s;
    b = -longint'(gy) * s;
    root = int_sqrt(longint'(a * a) + longint'(b * b) + UNIT_Z * UNIT_Z);
    res.x = encode(a, root, cur_inv_x);
    res.y = encode(b, root, cur_inv_y);
    res.z = encode(longint'(UNIT_Z), root, 1'b0);
    res.last = 1'b0;
    res.eof = 1'b0;
    return res;
  endfunction

  function automatic int unsigned eff_width();
    return cur_width == 0 ? 1 : (cur_width > LINE_MAX ? LINE_MAX : cur_width);
  endfunction

  function automatic int unsigned eff_height();
    return cur_height == 0 ? 1 : cur_height;
  endfunction

  // n = -1 when the item is dropped
  task automatic predict_normals(bit cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 output int n);
    int unsigned c;
    bit flushing;
    bit last_col;
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
    logic [7:0] w [3][3];
    normal_t res;
    flushing = row_cnt >= eff_height();
    n = 0;
    if (cmd && !flushing) begin
      n = -1;
      return;
    end
    c = col_cnt >= LINE_MAX ? LINE_MAX - 1 : col_cnt;
    last_col = c >= eff_width() - 1;
    mid = line_mid[c];
    top = row_cnt == 1 ? mid : line_above[c];
    bot = flushing ? mid : 8'((77 * r + 150 * g + 29 * b + 128) >> 8);
    line_above[c] = mid;
    line_mid[c] = bot;
    for (int i = 0; i < 6; i++) win_cols[i] = win_cols[i + 3];
    win_cols[6] = top;
    win_cols[7] = mid;
    win_cols[8] = bot;
    if (row_cnt >= 1) begin
      if (c >= 1) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) w[i][j] = win_cols[i * 3 + j];
        if (c == 1)
          for (int j = 0; j < 3; j++) w[0][j] = w[1][j];
        normal_q.push_back(shade(w));
        n++;
      end
      if (last_col) begin
        for (int j = 0; j < 3; j++) begin
          w[0][j] = win_cols[(c == 0 ? 6 : 3) + j];
          w[1][j] = win_cols[6 + j];
          w[2][j] = win_cols[6 + j];
        end
        res = shade(w);
        res.eof = flushing;
        normal_q.push_back(res);
        n++;
      end
      if (n > 0) normal_q[normal_q.size() - 1].last = 1'b1;
    end
    if (last_col) begin
      col_cnt = 0;
      row_cnt = flushing ? 0 : row_cnt + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_WIDTH:     cur_width = value[10:0];
      REG_HEIGHT:    cur_height = value;
      REG_STRENGTH:  cur_strength = value[13:0];
      REG_INV_RED:   cur_inv_x = value[0];
      REG_INV_GREEN: cur_inv_y = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned s, bit ix, bit iy);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_STRENGTH, s);
    write_reg(REG_INV_RED, ix);
    write_reg(REG_INV_GREEN, iy);
  endtask

  task automatic send_pixel(bit cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            output int n);
    if (burst_left == 0) begin
      pix.valid = 1'b0;
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    pix.valid = 1'b1;
    pix.command = cmd;
    pix.red = r;
    pix.green = g;
    pix.blue = b;
    do @(posedge clk); while (!pix.ready);
    predict_normals(cmd, r, g, b, n);
    if (n >= 0) pixels_taken++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    pix.valid = 1'b0;
    wait (normal_q.size() == 0);
    repeat (150) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_level(int mode);
    case (mode)
      0: return $urandom_range(0, 255);
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'd120 + $urandom_range(0, 12);
    endcase
  endfunction

  always @(posedge clk) begin
    normal_t want;
    if (!rst && nrm.valid && nrm.ready) begin
      if (normal_q.size() == 0) begin
        report("unexpected normal transfer");
      end else begin
        want = normal_q.pop_front();
        if (nrm.normal_x !== want.x)
          report($sformatf("normal_x %0d, want %0d", nrm.normal_x, want.x));
        if (nrm.normal_y !== want.y)
          report($sformatf("normal_y %0d, want %0d", nrm.normal_y, want.y));
        if (nrm.normal_z !== want.z)
          report($sformatf("normal_z %0d, want %0d", nrm.normal_z, want.z));
        if (nrm.last_of_run !== want.last)
          report($sformatf("last_of_run %0b, want %0b", nrm.last_of_run, want.last));
        if (nrm.end_of_frame !== want.eof)
          report($sformatf("end_of_frame %0b, want %0b", nrm.end_of_frame, want.eof));
      end
    end
  end

  initial begin
    int mode;
    int span;
    nrm.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: nrm.ready = 1'b1;
          1: nrm.ready = $urandom_range(0, 1);
          default: nrm.ready = $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  initial begin
    #60000000;
    $display("sobel_normal_map_generator verification failed");
    $finish;
  end

  pix_row_t plan [] = '{
    '{1, 8'd0, 8'd0, 8'd0, 1, 8'd128, 8'd128, 8'd255},
    '{0, 8'd255, 8'd255, 8'd255, 1, 8'd128, 8'd128, 8'd255},
    '{0, 8'd255, 8'd255, 8'd255, 1, 8'd128, 8'd128, 8'd255},
    '{0, 8'd255, 8'd255, 8'd255, 1, 8'd128, 8'd128, 8'd255},
    '{0, 8'd255, 8'd255, 8'd255, 1, 8'd128, 8'd128, 8'd255},
    '{1, 8'd0, 8'd0, 8'd0, 1, 8'd128, 8'd128, 8'd255},
    '{1, 8'd0, 8'd0, 8'd0, 1, 8'd128, 8'd128, 8'd255},
    '{0, 8'd255, 8'd255, 8'd255, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd0, 8'd0, 8'd0, 0, 8'd0, 8'd0, 8'd0},
    '{1, 8'd0, 8'd0, 8'd0, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd0, 8'd0, 8'd0, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd255, 8'd255, 8'd255, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd7, 8'd7, 8'd7, 0, 8'd0, 8'd0, 8'd0},
    '{1, 8'd0, 8'd0, 8'd0, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd255, 8'd0, 8'd0, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd0, 8'd255, 8'd0, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd0, 8'd0, 8'd255, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd170, 8'd85, 8'd170, 0, 8'd0, 8'd0, 8'd0},
    '{1, 8'd0, 8'd0, 8'd0, 0, 8'd0, 8'd0, 8'd0},
    '{0, 8'd85, 8'd170, 8'd85, 0, 8'd0, 8'd0, 8'd0}
  };

  int unsigned edge_w [5] = '{1, 0, 3, 1500, 5};
  int unsigned edge_h [5] = '{1, 4, 0, 1, 3};
  int unsigned edge_s [5] = '{0, 8192, 16383, 256, 1};

  initial begin
    int n;
    int frame_no;
    int mode;
    int unsigned w;
    int unsigned h;
    int unsigned s;
    int unsigned wl;
    int unsigned hl;
    pix.valid = 1'b0;
    pix.command = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_WIDTH;
    cfg.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    configure(2, 2, 256, 0, 0);
    foreach (plan[i]) begin
      send_pixel(plan[i].cmd, plan[i].r, plan[i].g, plan[i].b, n);
      if (plan[i].typed)
        for (int k = 1; k <= n; k++) begin
          normal_q[normal_q.size() - k].x = plan[i].tx;
          normal_q[normal_q.size() - k].y = plan[i].ty;
          normal_q[normal_q.size() - k].z = plan[i].tz;
        end
    end
    send_pixel(1, 0, 0, 0, n);
    send_pixel(1, 0, 0, 0, n);
    drain();

    frame_no = 0;
    while (frame_no < 5 || pixels_taken < 1650) begin
      if (frame_no < 5) begin
        if (frame_no == 0) write_reg(REG_HEIGHT, 16'd65535);
        w = edge_w[frame_no];
        h = edge_h[frame_no];
        s = edge_s[frame_no];
      end else begin
        w = $urandom_range(0, 7) == 0 ? $urandom_range(9, 48) : $urandom_range(1, 8);
        h = $urandom_range(1, 5);
        case ($urandom_range(0, 4))
          0: s = 0;
          1: s = 8192;
          2: s = $urandom_range(0, 16383);
          default: s = $urandom_range(0, 1024);
        endcase
      end
      configure(w, h, s, $urandom_range(0, 1), $urandom_range(0, 1));
      wl = eff_width();
      hl = eff_height();
      mode = $urandom_range(0, 2);
      for (int row = 0; row < hl; row++)
        for (int col = 0; col < wl; col++) begin
          if ($urandom_range(0, 19) == 0)
            send_pixel(1, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), n);
          send_pixel(0, pick_level(mode), pick_level(mode), pick_level(mode), n);
        end
      for (int col = 0; col < wl; col++)
        send_pixel($urandom_range(0, 9) != 0, $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), n);
      drain();
      frame_no++;
    end

    if (errors == 0)
      $display("sobel_normal_map_generator verification clean");
    else
      $display("sobel_normal_map_generator verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/snm_pkg.sv
sv/snm_if.sv
sv/snm_cfg.sv
sv/snm_emit.sv
sv/snm_core.sv
sv/sobel_normal_map_generator.sv
sv/snm_checker.sv
tb/sobel_normal_map_generator_tb.sv
